/* hw/rtl/fcpq_pkg.sv */
// Shared types and constants for the four-class priority queue.
// No dependencies; every other file imports this package.
package fcpq_pkg;

    localparam int ID_W            = 17;
    localparam int CLS_W           = 2;
    localparam int SLOT_W          = 4;
    localparam int NUM_CLASSES     = 4;
    localparam int IN_DATA_W       = 24;
    localparam int OUT_DATA_W      = 24;

    localparam int CLASS_DEPTH_DEF = 16;
    localparam int TABLE_SLOTS_DEF = 10;
    localparam int ID_DIGITS_DEF   = 5;

    // exact floor(v / 10) for any 32-bit v: (v * RECIP10) >> RECIP_SHIFT
    localparam int          RADIX       = 10;
    localparam logic [31:0] RECIP10     = 32'hCCCCCCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          PROD_W      = ID_W + 32;

    typedef enum logic [1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_CALL = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NONE = 2'd3
    } fcpq_func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NO_SLOT = 2'd3
    } fcpq_status_t;

    // request context carried down the pipeline
    typedef struct packed {
        fcpq_func_t         func;
        logic [CLS_W-1:0]   cls;
        logic [SLOT_W-1:0]  sel;
        fcpq_status_t       status;
        logic               hit;     // call removed a record
    } fcpq_ctl_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CLS_W-1:0]   cls;
        logic [SLOT_W-1:0]  slot;
        fcpq_status_t       status;
    } fcpq_res_t;

    // class 0 critical (1,1) ... class 3 low (0,0)
    function automatic logic [CLS_W-1:0] class_of(input logic impact, input logic likely);
        return {~impact, ~likely};
    endfunction

endpackage

/* hw/rtl/four_class_priority_queue.sv */
// Channel  Dir  tdata bits (low first)                         tuser
// s_axis   in   rec_id[16:0] impact[17] likely[18] sel[22:19]   func[1:0]
// m_axis   out  out_id[16:0] out_class[18:17] out_slot[22:19]   status[1:0]
//
// One request per cycle while s_axis_tready is high; a result passes the input register, the
// queue memory read, one digit-hash stage per decimal digit, the slot table and the result FIFO.
// Reset (aresetn low, synchronous) empties all class queues and the table valid bits.
// Credit-based: s_axis_tready drops only once ID_DIGITS + 5 requests sit unread,
// so a stalled m_axis side holds results without blocking intake until then.
// Top level; depends on fcpq_pkg and the fcpq_* submodules.
module four_class_priority_queue
    import fcpq_pkg::*;
#(
    parameter int CLASS_DEPTH = CLASS_DEPTH_DEF,
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int ID_DIGITS   = ID_DIGITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // rec_id, impact_bit, likely_bit, slot_sel
    input  logic [1:0]            s_axis_tuser,   // func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_id, out_class, out_slot, pad
    output logic [1:0]            m_axis_tuser    // status
);

    localparam int ACC_W     = $clog2(TABLE_SLOTS + 9);
    localparam int OUT_DEPTH = ID_DIGITS + 5;

    logic      accept;
    logic      stg_valid [ID_DIGITS+1];
    fcpq_ctl_t stg_ctl   [ID_DIGITS+1];
    logic [ID_W-1:0]  stg_id  [ID_DIGITS+1];
    logic [ID_W-1:0]  stg_rem [ID_DIGITS+1];
    logic [ACC_W-1:0] stg_acc [ID_DIGITS+1];

    logic      tbl_valid;
    fcpq_res_t tbl_res, out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    fcpq_queue_ctl #(.CLASS_DEPTH(CLASS_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_func   (fcpq_func_t'(s_axis_tuser)),
        .in_id     (s_axis_tdata[16:0]),
        .in_impact (s_axis_tdata[17]),
        .in_likely (s_axis_tdata[18]),
        .in_sel    (s_axis_tdata[22:19]),
        .out_valid (stg_valid[0]),
        .out_ctl   (stg_ctl[0]),
        .out_id    (stg_id[0])
    );

    assign stg_rem[0] = stg_id[0];
    assign stg_acc[0] = '0;

    for (genvar d = 0; d < ID_DIGITS; d++) begin : g_digit
        fcpq_digit_stage #(.TABLE_SLOTS(TABLE_SLOTS)) u_digit (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[d]),
            .in_ctl    (stg_ctl[d]),
            .in_id     (stg_id[d]),
            .in_rem    (stg_rem[d]),
            .in_acc    (stg_acc[d]),
            .out_valid (stg_valid[d+1]),
            .out_ctl   (stg_ctl[d+1]),
            .out_id    (stg_id[d+1]),
            .out_rem   (stg_rem[d+1]),
            .out_acc   (stg_acc[d+1])
        );
    end

    fcpq_slot_table #(.TABLE_SLOTS(TABLE_SLOTS)) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stg_valid[ID_DIGITS]),
        .in_ctl    (stg_ctl[ID_DIGITS]),
        .in_id     (stg_id[ID_DIGITS]),
        .in_acc    (stg_acc[ID_DIGITS]),
        .out_valid (tbl_valid),
        .out_res   (tbl_res)
    );

    fcpq_out_fifo #(.DEPTH(OUT_DEPTH)) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_ready  (s_axis_tready),
        .wr_valid  (tbl_valid),
        .wr_res    (tbl_res),
        .rd_valid  (m_axis_tvalid),
        .rd_ready  (m_axis_tready),
        .rd_res    (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.slot, out_res.cls, out_res.id};
    assign m_axis_tuser = out_res.status;

endmodule

/* hw/rtl/fcpq_queue_ctl.sv */
// Input register, per-class FIFO pointers and the shared id memory.
// Depends on fcpq_pkg.
module fcpq_queue_ctl
    import fcpq_pkg::*;
#(
    parameter int CLASS_DEPTH = CLASS_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  fcpq_func_t        in_func,
    input  logic [ID_W-1:0]   in_id,
    input  logic              in_impact,
    input  logic              in_likely,
    input  logic [SLOT_W-1:0] in_sel,
    output logic              out_valid,
    output fcpq_ctl_t         out_ctl,
    output logic [ID_W-1:0]   out_id
);

    localparam int PTR_W     = $clog2(CLASS_DEPTH);
    localparam int CNT_W     = $clog2(CLASS_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_CLASSES << PTR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CLASS_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CLASS_DEPTH);

    logic              s1_valid_reg;
    fcpq_func_t        s1_func_reg;
    logic [ID_W-1:0]   s1_id_reg;
    logic [CLS_W-1:0]  s1_cls_reg;
    logic [SLOT_W-1:0] s1_sel_reg;

    logic [PTR_W-1:0]  head_reg  [NUM_CLASSES];
    logic [PTR_W-1:0]  head_next [NUM_CLASSES];
    logic [PTR_W-1:0]  tail_reg  [NUM_CLASSES];
    logic [PTR_W-1:0]  tail_next [NUM_CLASSES];
    logic [CNT_W-1:0]  count_reg [NUM_CLASSES];
    logic [CNT_W-1:0]  count_next[NUM_CLASSES];

    logic [ID_W-1:0]   id_mem [MEM_DEPTH];
    logic [ID_W-1:0]   rd_data_reg;

    logic              s2_valid_reg;
    fcpq_ctl_t         s2_ctl_reg;
    fcpq_ctl_t         s2_ctl_next;

    logic              is_push, is_call, push_full, push_ok, call_ok, any_busy;
    logic [CLS_W-1:0]  pick_cls;
    logic [CLS_W+PTR_W-1:0] wr_addr, rd_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
        end
        if (in_valid) begin
            s1_func_reg <= in_func;
            s1_id_reg   <= in_id;
            s1_cls_reg  <= class_of(in_impact, in_likely);
            s1_sel_reg  <= in_sel;
        end
    end

    always_comb begin
        is_push   = s1_valid_reg && (s1_func_reg == FUNC_PUSH);
        is_call   = s1_valid_reg && (s1_func_reg == FUNC_CALL);
        push_full = (count_reg[s1_cls_reg] == CNT_FULL);
        push_ok   = is_push && !push_full;

        // highest-priority non-empty class wins (class 0 first)
        any_busy = 1'b1;
        pick_cls = '0;
        priority if (count_reg[0] != '0) pick_cls = CLS_W'(0);
        else if (count_reg[1] != '0)     pick_cls = CLS_W'(1);
        else if (count_reg[2] != '0)     pick_cls = CLS_W'(2);
        else if (count_reg[3] != '0)     pick_cls = CLS_W'(3);
        else                             any_busy = 1'b0;
        call_ok = is_call && any_busy;

        wr_addr = {s1_cls_reg, tail_reg[s1_cls_reg]};
        rd_addr = {pick_cls, head_reg[pick_cls]};

        for (int c = 0; c < NUM_CLASSES; c++) begin
            head_next[c]  = head_reg[c];
            tail_next[c]  = tail_reg[c];
            count_next[c] = count_reg[c];
        end
        if (push_ok) begin
            tail_next[s1_cls_reg]  = (tail_reg[s1_cls_reg] == PTR_LAST) ? '0
                                   : tail_reg[s1_cls_reg] + PTR_W'(1);
            count_next[s1_cls_reg] = count_reg[s1_cls_reg] + CNT_W'(1);
        end
        if (call_ok) begin
            head_next[pick_cls]  = (head_reg[pick_cls] == PTR_LAST) ? '0
                                 : head_reg[pick_cls] + PTR_W'(1);
            count_next[pick_cls] = count_reg[pick_cls] - CNT_W'(1);
        end

        s2_ctl_next.func   = s1_func_reg;
        s2_ctl_next.cls    = '0;
        s2_ctl_next.sel    = '0;
        s2_ctl_next.status = ST_OK;
        s2_ctl_next.hit    = call_ok;
        unique case (s1_func_reg)
            FUNC_PUSH: begin
                s2_ctl_next.cls    = s1_cls_reg;
                s2_ctl_next.status = push_full ? ST_FULL : ST_OK;
            end
            FUNC_CALL: begin
                s2_ctl_next.cls    = call_ok ? pick_cls : '0;
                s2_ctl_next.status = call_ok ? ST_OK : ST_EMPTY;
            end
            FUNC_READ: s2_ctl_next.sel = s1_sel_reg;
            FUNC_NONE: s2_ctl_next.status = ST_OK;
            default:   s2_ctl_next.status = ST_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end else begin
            s2_valid_reg <= s1_valid_reg;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c]  <= head_next[c];
                tail_reg[c]  <= tail_next[c];
                count_reg[c] <= count_next[c];
            end
        end
        s2_ctl_reg <= s2_ctl_next;
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            id_mem[wr_addr] <= s1_id_reg;
        end
        rd_data_reg <= id_mem[rd_addr];
    end

    assign out_valid = s2_valid_reg;
    assign out_ctl   = s2_ctl_reg;
    assign out_id    = s2_ctl_reg.hit ? rd_data_reg : '0;

endmodule

/* hw/rtl/fcpq_digit_stage.sv */
// One decimal digit of the slot hash: peels the low digit off and folds it
// into the running sum mod TABLE_SLOTS. Depends on fcpq_pkg.
module fcpq_digit_stage
    import fcpq_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    input  fcpq_ctl_t                              in_ctl,
    input  logic [ID_W-1:0]                        in_id,
    input  logic [ID_W-1:0]                        in_rem,
    input  logic [$clog2(TABLE_SLOTS + 9)-1:0]     in_acc,
    output logic                                   out_valid,
    output fcpq_ctl_t                              out_ctl,
    output logic [ID_W-1:0]                        out_id,
    output logic [ID_W-1:0]                        out_rem,
    output logic [$clog2(TABLE_SLOTS + 9)-1:0]     out_acc
);

    localparam int ACC_W     = $clog2(TABLE_SLOTS + 9);
    localparam int RED_STEPS = (TABLE_SLOTS + 8) / TABLE_SLOTS;
    localparam logic [ACC_W-1:0] SLOTS = ACC_W'(TABLE_SLOTS);

    logic [PROD_W-1:0] prod;
    logic [ID_W-1:0]   quot, tens;
    logic [3:0]        digit;
    logic [ACC_W-1:0]  sum;

    logic              valid_reg;
    fcpq_ctl_t         ctl_reg;
    logic [ID_W-1:0]   id_reg, rem_reg;
    logic [ACC_W-1:0]  acc_reg;

    always_comb begin
        prod  = PROD_W'(in_rem) * PROD_W'(RECIP10);
        quot  = ID_W'(prod >> RECIP_SHIFT);
        tens  = (quot << 3) + (quot << 1);
        digit = 4'(in_rem - tens);
        sum   = in_acc + ACC_W'(digit);
        for (int k = 0; k < RED_STEPS; k++) begin
            if (sum >= SLOTS) begin
                sum = sum - SLOTS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
        ctl_reg <= in_ctl;
        id_reg  <= in_id;
        rem_reg <= quot;
        acc_reg <= sum;
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_id    = id_reg;
    assign out_rem   = rem_reg;
    assign out_acc   = acc_reg;

endmodule

/* hw/rtl/fcpq_slot_table.sv */
// Processed-record table: written by a successful call, read by a slot
// read; also builds the final result. Depends on fcpq_pkg.
module fcpq_slot_table
    import fcpq_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    input  fcpq_ctl_t                              in_ctl,
    input  logic [ID_W-1:0]                        in_id,
    input  logic [$clog2(TABLE_SLOTS + 9)-1:0]     in_acc,
    output logic                                   out_valid,
    output fcpq_res_t                              out_res
);

    localparam int TS_W = $clog2(TABLE_SLOTS);

    logic [ID_W+CLS_W-1:0] tbl_mem [TABLE_SLOTS];
    logic [ID_W+CLS_W-1:0] rd_data_reg;
    logic                  slot_valid_reg [TABLE_SLOTS];

    logic                  wr_en, rd_en, sel_ok;
    logic [TS_W-1:0]       wr_idx, rd_idx;
    logic [SLOT_W-1:0]     slot_next;

    logic                  t_valid_reg;
    fcpq_ctl_t             t_ctl_reg;
    logic [ID_W-1:0]       t_id_reg;
    logic [SLOT_W-1:0]     t_slot_reg;
    logic                  t_found_reg;

    always_comb begin
        wr_en  = in_valid && in_ctl.hit;
        wr_idx = TS_W'(in_acc);
        sel_ok = int'(in_ctl.sel) < TABLE_SLOTS;
        rd_idx = TS_W'(in_ctl.sel);
        rd_en  = in_valid && (in_ctl.func == FUNC_READ) && sel_ok;
        unique case (in_ctl.func)
            FUNC_CALL: slot_next = in_ctl.hit ? SLOT_W'(in_acc) : '0;
            FUNC_READ: slot_next = in_ctl.sel;
            default:   slot_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_valid_reg[i] <= 1'b0;
            end
        end else begin
            t_valid_reg <= in_valid;
            if (wr_en) begin
                slot_valid_reg[wr_idx] <= 1'b1;
            end
        end
        t_ctl_reg   <= in_ctl;
        t_id_reg    <= in_id;
        t_slot_reg  <= slot_next;
        t_found_reg <= rd_en ? slot_valid_reg[rd_idx] : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[wr_idx] <= {in_id, in_ctl.cls};
        end
        if (rd_en) begin
            rd_data_reg <= tbl_mem[rd_idx];
        end
    end

    always_comb begin
        out_res.id     = t_id_reg;
        out_res.cls    = t_ctl_reg.cls;
        out_res.slot   = t_slot_reg;
        out_res.status = t_ctl_reg.status;
        if (t_ctl_reg.func == FUNC_READ) begin
            if (t_found_reg) begin
                out_res.id     = rd_data_reg[ID_W+CLS_W-1:CLS_W];
                out_res.cls    = rd_data_reg[CLS_W-1:0];
                out_res.status = ST_OK;
            end else begin
                out_res.id     = '0;
                out_res.cls    = '0;
                out_res.status = ST_NO_SLOT;
            end
        end
    end

    assign out_valid = t_valid_reg;

endmodule

/* hw/rtl/fcpq_out_fifo.sv */
// Result FIFO plus a credit count of every request in flight, so the
// pipeline never has to stall. Depends on fcpq_pkg.
module fcpq_out_fifo
    import fcpq_pkg::*;
#(
    parameter int DEPTH = ID_DIGITS_DEF + 5
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_accept,
    output logic      in_ready,
    input  logic      wr_valid,
    input  fcpq_res_t wr_res,
    output logic      rd_valid,
    input  logic      rd_ready,
    output fcpq_res_t rd_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(DEPTH);

    fcpq_res_t       buf_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   credit_reg, credit_next;
    logic            pop;

    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (fill_reg != '0);
    assign rd_res   = buf_reg[rd_ptr_reg];
    assign in_ready = (credit_reg != CNT_MAX);

    always_comb begin
        unique case ({wr_valid, pop})
            2'b10:   fill_next = fill_reg + CW'(1);
            2'b01:   fill_next = fill_reg - CW'(1);
            default: fill_next = fill_reg;
        endcase
        unique case ({in_accept, pop})
            2'b10:   credit_next = credit_reg + CW'(1);
            2'b01:   credit_next = credit_reg - CW'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end else begin
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
            if (wr_valid) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
        if (wr_valid) begin
            buf_reg[wr_ptr_reg] <= wr_res;
        end
    end

endmodule

/* hw/rtl/fcpq_checker.sv */
// Port-level checks for four_class_priority_queue, bound to the top level.
// Depends on fcpq_pkg.
module fcpq_checker
    import fcpq_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser
);

    // nothing comes out in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a call on an empty queue reports nothing but the status
    a_empty_call: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata == '0))
        else $error("empty-queue result carries data");

    // a rejected push reports only its class
    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ST_FULL)
        |-> (m_axis_tdata[16:0] == '0 && m_axis_tdata[23:19] == '0))
        else $error("full-class result carries id or slot");

    // an empty slot read reports no id and no class
    a_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ST_NO_SLOT) |-> (m_axis_tdata[18:0] == '0))
        else $error("empty-slot result carries id or class");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind four_class_priority_queue fcpq_checker u_fcpq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/four_class_priority_queue_chk.sv */
// Checker for the four-class priority queue: watches both stream channels,
// predicts each response and compares it field by field. Depends on fcpq_pkg.
`timescale 1ns / 1ps

module four_class_priority_queue_chk
    import fcpq_pkg::*;
#(
    parameter int CLASS_DEPTH = CLASS_DEPTH_DEF,
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int ID_DIGITS   = ID_DIGITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // rec_id, impact_bit, likely_bit, slot_sel
    input  logic [1:0]            s_axis_tuser,   // func
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_id, out_class, out_slot, pad
    input  logic [1:0]            m_axis_tuser,   // status
    output int                    err_cnt,
    output int                    open_cnt
);

    localparam logic [CLS_W-1:0] CLS_CRIT = 2'd0;
    localparam logic [CLS_W-1:0] CLS_HIGH = 2'd1;
    localparam logic [CLS_W-1:0] CLS_MED  = 2'd2;
    localparam logic [CLS_W-1:0] CLS_LOW  = 2'd3;

    // shadow queue and table state
    logic [ID_W-1:0]  fifo_mem [NUM_CLASSES*CLASS_DEPTH];
    int unsigned      head_p [NUM_CLASSES];
    int unsigned      tail_p [NUM_CLASSES];
    int unsigned      occ [NUM_CLASSES];
    logic [ID_W-1:0]  tab_id [TABLE_SLOTS];
    logic [CLS_W-1:0] tab_cls [TABLE_SLOTS];
    bit               tab_ok [TABLE_SLOTS];

    fcpq_res_t due_res_q[$];
    fcpq_res_t want;

    initial begin
        err_cnt  = 0;
        open_cnt = 0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            head_p[i] = 0;
            tail_p[i] = 0;
            occ[i]    = 0;
        end
        for (int i = 0; i < TABLE_SLOTS; i++)
            tab_ok[i] = 1'b0;
    end

    function automatic int unsigned digit_slot(input logic [ID_W-1:0] id);
        int unsigned v;
        int unsigned acc;
        v   = 32'(id);
        acc = 0;
        for (int i = 0; i < ID_DIGITS; i++) begin
            acc += v % 10;
            v   /= 10;
        end
        return acc % TABLE_SLOTS;
    endfunction

    function automatic fcpq_res_t predict_req(input fcpq_func_t f,
                                              input logic [ID_W-1:0] id,
                                              input logic imp,
                                              input logic lik,
                                              input logic [SLOT_W-1:0] sel);
        fcpq_res_t        r;
        logic [CLS_W-1:0] c;
        int unsigned      s;
        bit               found;
        r     = '0;
        found = 1'b0;
        case (f)
            FUNC_PUSH: begin
                if (imp)
                    c = lik ? CLS_CRIT : CLS_HIGH;
                else
                    c = lik ? CLS_MED : CLS_LOW;
                r.cls = c;
                if (occ[c] >= CLASS_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    fifo_mem[c*CLASS_DEPTH + tail_p[c]] = id;
                    tail_p[c] = (tail_p[c] + 1) % CLASS_DEPTH;
                    occ[c]++;
                    r.status = ST_OK;
                end
            end
            FUNC_CALL: begin
                r.status = ST_EMPTY;
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    if (!found && occ[k] != 0) begin
                        found = 1'b1;
                        r.id  = fifo_mem[k*CLASS_DEPTH + head_p[k]];
                        r.cls = CLS_W'(k);
                        s = digit_slot(r.id);
                        r.slot = SLOT_W'(s);
                        r.status = ST_OK;
                        head_p[k] = (head_p[k] + 1) % CLASS_DEPTH;
                        occ[k]--;
                        tab_id[s]  = r.id;
                        tab_cls[s] = CLS_W'(k);
                        tab_ok[s]  = 1'b1;
                    end
                end
            end
            FUNC_READ: begin
                r.slot = sel;
                if (sel < TABLE_SLOTS && tab_ok[sel]) begin
                    r.id     = tab_id[sel];
                    r.cls    = tab_cls[sel];
                    r.status = ST_OK;
                end else begin
                    r.status = ST_NO_SLOT;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string fname, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", fname, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                due_res_q.push_back(predict_req(fcpq_func_t'(s_axis_tuser),
                                                s_axis_tdata[16:0], s_axis_tdata[17],
                                                s_axis_tdata[18], s_axis_tdata[22:19]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_res_q.size() == 0) begin
                    $error("response with no request outstanding");
                    err_cnt++;
                end else begin
                    want = due_res_q.pop_front();
                    check_field("out_id", want.id, m_axis_tdata[16:0]);
                    check_field("out_class", want.cls, m_axis_tdata[18:17]);
                    check_field("out_slot", want.slot, m_axis_tdata[22:19]);
                    check_field("status", want.status, m_axis_tuser);
                end
            end
        end
        // registered: shows the queue size after this edge's handshakes
        open_cnt <= due_res_q.size();
    end

endmodule

/* tb/sv/four_class_priority_queue_tb.sv */
// Testbench top for the four-class priority queue: clock, reset, request
// stimulus, response back-pressure and verdict. Depends on fcpq_pkg and the checker.
`timescale 1ns / 1ps

module four_class_priority_queue_tb
    import fcpq_pkg::*;
();

    localparam int N_RAND      = 1125;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_AT    = 200;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AFTER  = 450;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // rec_id, impact_bit, likely_bit, slot_sel
    logic [1:0]            s_axis_tuser  = '0;   // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // out_id, out_class, out_slot, pad
    logic [1:0]            m_axis_tuser;         // status

    int err_cnt;
    int open_cnt;

    four_class_priority_queue dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    four_class_priority_queue_chk chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .err_cnt       (err_cnt),
        .open_cnt      (open_cnt)
    );

    always #10 aclk = ~aclk;

    // response side: random stall modes, plus one long hold-off mid-run
    int rx_mode    = 0;
    int rx_span    = 0;
    int rx_hold    = 0;
    int rx_seen    = 0;
    bit rx_held    = 1'b0;

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            rx_seen++;
        if (!rx_held && rx_seen >= HOLD_AFTER) begin
            rx_held = 1'b1;
            rx_hold = LONG_HOLD;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_span == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_span = $urandom_range(5, 60);
            end else begin
                rx_span--;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    // hard stop
    int unsigned cyc = 0;
    initial begin
        while (cyc < CYCLE_LIMIT) begin
            @(posedge aclk);
            cyc++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_req(input fcpq_func_t f, input logic [ID_W-1:0] id,
                            input logic imp, input logic lik,
                            input logic [SLOT_W-1:0] sel);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, sel, lik, imp, id};
        s_axis_tuser  <= f;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (open_cnt != 0);
    endtask

    int               gap;
    int               burst_left;
    int               push_pct;
    int               pick;
    bit               fav_on;
    logic             fav_imp;
    logic             fav_lik;
    fcpq_func_t       f;
    logic [ID_W-1:0]  id;
    logic             imp;
    logic             lik;
    logic [SLOT_W-1:0] sel;

    initial begin
        burst_left = 0;
        push_pct   = 50;
        fav_on     = 1'b0;
        fav_imp    = 1'b0;
        fav_lik    = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty call, empty and out-of-range reads, unused code,
        // one push per class incl. an id wider than five digits, then a full class
        send_req(FUNC_CALL, '1, 1'b1, 1'b1, 4'd3);
        send_req(FUNC_READ, '0, 1'b0, 1'b0, 4'd0);
        send_req(FUNC_READ, '0, 1'b0, 1'b0, 4'd15);
        send_req(FUNC_NONE, '1, 1'b1, 1'b1, '1);
        send_req(FUNC_PUSH, 17'd99999, 1'b1, 1'b1, 4'd0);
        send_req(FUNC_PUSH, 17'd12345, 1'b1, 1'b0, 4'd0);
        send_req(FUNC_PUSH, 17'h1FFFF, 1'b0, 1'b1, 4'hF);
        for (int k = 0; k < 17; k++)
            send_req(FUNC_PUSH, ID_W'(k * 7919), 1'b0, 1'b0, 4'd0);
        send_req(FUNC_CALL, '0, 1'b0, 1'b0, 4'd0);

        for (int n = 0; n < N_RAND; n++) begin
            if (n == DRAIN_AT)
                wait_drained();
            if (n % 64 == 0) begin
                push_pct = $urandom_range(15, 85);
                fav_on   = 1'($urandom_range(0, 1));
                fav_imp  = 1'($urandom_range(0, 1));
                fav_lik  = 1'($urandom_range(0, 1));
            end
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(0, 3);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;

            id  = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, 131071))
                                              : ID_W'($urandom_range(0, 99999));
            imp = 1'($urandom_range(0, 1));
            lik = 1'($urandom_range(0, 1));
            sel = SLOT_W'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < push_pct) begin
                f = FUNC_PUSH;
                if (fav_on && $urandom_range(0, 1)) begin
                    imp = fav_imp;
                    lik = fav_lik;
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    f = FUNC_CALL;
                end else if (pick < 96) begin
                    f = FUNC_READ;
                    if ($urandom_range(0, 6) != 0)
                        sel = SLOT_W'($urandom_range(0, 9));
                end else begin
                    f = FUNC_NONE;
                end
            end
            send_req(f, id, imp, lik, sel);
        end

        wait_drained();
        repeat (ID_DIGITS_DEF + 20) @(posedge aclk);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
